@@ src/fmacl_pkg.sv @@
// Shared types, codes and constants of the first-match access list block.
package fmacl_pkg;

  localparam int NUM_LISTS_DEF      = 16;
  localparam int RULES_PER_LIST_DEF = 16;

  // List numbers are widened to this many bits before they are compared or scaled.
  localparam int LIST_WIDE_W = 7;
  // Width of the slot arithmetic (list base plus rule index).
  localparam int SLOT_SUM_W  = 16;

  localparam logic [7:0] MAX_PREFIX = 8'd128;
  localparam logic [7:0] HALF_ADDR  = 8'd64;

  localparam logic KIND_V4 = 1'b0;
  localparam logic KIND_V6 = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    OP_ADD_V4   = 3'd0,
    OP_ADD_V6   = 3'd1,
    OP_CLEAR    = 3'd2,
    OP_MATCH_V4 = 3'd3,
    OP_MATCH_V6 = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_COUNT = 2'd1,
    ST_WALK  = 2'd2,
    ST_DONE  = 2'd3
  } state_t;

  // One stored rule as it sits in the rule memory.
  typedef struct packed {
    logic        kind;
    logic        permit;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [31:0] mask_or_len;
  } rule_t;

  // Address bits needed for a store of the given depth.
  function automatic int addr_bits(input int depth);
    int bits;
    bits = (depth > 1) ? $clog2(depth) : 1;
    return bits;
  endfunction

endpackage

@@ src/fmacl_req_if.sv @@
// Request channel: one operation on an access list.
interface fmacl_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [3:0]  list_index;
  logic [63:0] addr_hi;
  logic [63:0] addr_lo;
  logic [31:0] ipv4_mask;
  logic [7:0]  prefix_len;
  logic        permit_in;

  modport source (
    output valid, opcode, list_index, addr_hi, addr_lo, ipv4_mask, prefix_len, permit_in,
    input  ready
  );
  modport sink (
    input  valid, opcode, list_index, addr_hi, addr_lo, ipv4_mask, prefix_len, permit_in,
    output ready
  );
endinterface

@@ src/fmacl_rsp_if.sv @@
// Result channel: verdict and status of one request.
interface fmacl_rsp_if;
  logic valid;
  logic ready;
  logic permitted;
  logic explicit_hit;
  logic status;

  modport source (
    output valid, permitted, explicit_hit, status,
    input  ready
  );
  modport sink (
    input  valid, permitted, explicit_hit, status,
    output ready
  );
endinterface

@@ src/fmacl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fmacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [fmacl_pkg::addr_bits(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [fmacl_pkg::addr_bits(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/fmacl_match.sv @@
// Rule compare unit: decides whether one stored rule hits the address.
module fmacl_match (
  input  logic             v6,
  input  logic [63:0]      addr_hi,
  input  logic [63:0]      addr_lo,
  input  fmacl_pkg::rule_t rule,
  output logic             hit
);

  logic [7:0]  len;
  logic [7:0]  lo_len;
  logic [63:0] mask_hi;
  logic [63:0] mask_lo;
  logic        hit_v4;
  logic        hit_v6;

  always_comb begin
    len = (rule.mask_or_len[7:0] > fmacl_pkg::MAX_PREFIX) ? fmacl_pkg::MAX_PREFIX
                                                          : rule.mask_or_len[7:0];
    lo_len = len - fmacl_pkg::HALF_ADDR;

    // Prefix masks cover the top len bits of the 128-bit address.
    if (len >= fmacl_pkg::HALF_ADDR) begin
      mask_hi = '1;
    end else begin
      mask_hi = ~({64{1'b1}} >> len[5:0]);
    end

    if (len >= fmacl_pkg::MAX_PREFIX) begin
      mask_lo = '1;
    end else if (len <= fmacl_pkg::HALF_ADDR) begin
      mask_lo = '0;
    end else begin
      mask_lo = ~({64{1'b1}} >> lo_len[5:0]);
    end

    hit_v4 = (rule.kind == fmacl_pkg::KIND_V4) &&
             ((addr_lo[31:0] & rule.mask_or_len) == rule.addr_lo[31:0]);
    hit_v6 = (rule.kind == fmacl_pkg::KIND_V6) &&
             ((addr_hi & mask_hi) == rule.addr_hi) &&
             ((addr_lo & mask_lo) == rule.addr_lo);
    hit = v6 ? hit_v6 : hit_v4;
  end

endmodule

@@ src/first_match_ip_acl.sv @@
// Top level of the first-match IP access list block: sequencer and storage.
//
//  Channel | Direction | Carries
//  --------+-----------+-----------------------------------------------------------
//  req     | in        | opcode, list_index, addr_hi, addr_lo, ipv4_mask,
//          |           | prefix_len, permit_in
//  rsp     | out       | permitted, explicit_hit, status
//
// A request is taken only when the block is idle. Add, clear and unknown requests offer
// their result from the done state that follows the count lookup state; a match on a
// non-empty list walks it in between, visiting 1 to RULES_PER_LIST rules, because the
// single compare unit checks one rule per cycle from the rule memory's read port.
// After the result is taken the block is ready again in the next cycle.
// Reset (rst, synchronous) empties every list at once through per-list valid bits;
// no clearing pass is needed. A stalled result simply holds the block in its done state.
module first_match_ip_acl #(
  parameter int NUM_LISTS      = fmacl_pkg::NUM_LISTS_DEF,
  parameter int RULES_PER_LIST = fmacl_pkg::RULES_PER_LIST_DEF
) (
  input logic         clk,
  input logic         rst,
  fmacl_req_if.sink   req,
  fmacl_rsp_if.source rsp
);

  localparam int TOTAL_RULES = NUM_LISTS * RULES_PER_LIST;
  localparam int LIST_AW     = fmacl_pkg::addr_bits(NUM_LISTS);
  localparam int RULE_AW     = fmacl_pkg::addr_bits(TOTAL_RULES);
  localparam int CNT_W       = $clog2(RULES_PER_LIST + 1);
  localparam int LW          = fmacl_pkg::LIST_WIDE_W;
  localparam int SW          = fmacl_pkg::SLOT_SUM_W;

  fmacl_pkg::state_t state;
  fmacl_pkg::state_t state_next;

  // Request captured at acceptance.
  fmacl_pkg::op_t op;
  logic             list_ok;
  logic [LIST_AW-1:0] list_idx;
  logic [SW-1:0]    base;
  logic [63:0]      addr_hi;
  logic [63:0]      addr_lo;
  logic [31:0]      ipv4_mask;
  logic [7:0]       prefix_len;
  logic             permit_in;

  // Walk state and result registers.
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] idx;
  logic             permitted;
  logic             explicit_hit;
  logic             status;

  // Per-list valid bits: a list whose bit is low holds no rules.
  logic [NUM_LISTS-1:0] cnt_vld;

  logic [LW-1:0]        list_wide_in;
  logic                 list_ok_in;
  logic [LIST_AW-1:0]   cnt_raddr;
  logic [CNT_W-1:0]     cnt_rdata;
  logic [CNT_W-1:0]     cnt_cur;
  logic                 cnt_we;
  logic [CNT_W-1:0]     cnt_wdata;

  logic                 rule_we;
  logic [SW-1:0]        rule_wslot;
  logic [SW-1:0]        rule_rslot;
  logic [CNT_W-1:0]     rd_idx;
  fmacl_pkg::rule_t     rule_wdata;
  fmacl_pkg::rule_t     rule_rdata;
  logic                 rule_hit;

  // Controls from the sequencer to the datapath registers.
  logic                 accept;
  logic                 load_cnt;
  logic                 step_idx;
  logic                 set_vld;
  logic                 clr_vld;
  logic                 load_res;
  logic                 res_permitted;
  logic                 res_hit;
  logic                 res_status;

  assign list_wide_in = LW'(req.list_index);
  assign list_ok_in   = list_wide_in < LW'(NUM_LISTS);
  assign cnt_raddr    = list_wide_in[LIST_AW-1:0];
  assign cnt_cur      = (list_ok && cnt_vld[list_idx]) ? cnt_rdata : '0;

  assign accept = req.valid && req.ready;

  // The rule read port runs one entry ahead of the compare unit.
  assign rd_idx     = (state == fmacl_pkg::ST_COUNT) ? '0 : CNT_W'(idx + 1'b1);
  assign rule_rslot = base + SW'(rd_idx);
  assign rule_wslot = base + SW'(cnt_cur);
  assign cnt_wdata  = CNT_W'(cnt_cur + 1'b1);

  always_comb begin
    rule_wdata.permit = permit_in;
    if (op == fmacl_pkg::OP_ADD_V6) begin
      rule_wdata.kind        = fmacl_pkg::KIND_V6;
      rule_wdata.addr_hi     = addr_hi;
      rule_wdata.addr_lo     = addr_lo;
      rule_wdata.mask_or_len = (prefix_len > fmacl_pkg::MAX_PREFIX)
                               ? 32'(fmacl_pkg::MAX_PREFIX) : 32'(prefix_len);
    end else begin
      rule_wdata.kind        = fmacl_pkg::KIND_V4;
      rule_wdata.addr_hi     = '0;
      rule_wdata.addr_lo     = {32'b0, addr_lo[31:0]};
      rule_wdata.mask_or_len = ipv4_mask;
    end
  end

  fmacl_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_LISTS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (list_idx),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  fmacl_ram #(
    .WIDTH ($bits(fmacl_pkg::rule_t)),
    .DEPTH (TOTAL_RULES)
  ) u_rule_ram (
    .clk   (clk),
    .we    (rule_we),
    .waddr (rule_wslot[RULE_AW-1:0]),
    .wdata (rule_wdata),
    .raddr (rule_rslot[RULE_AW-1:0]),
    .rdata (rule_rdata)
  );

  fmacl_match u_match (
    .v6      (op == fmacl_pkg::OP_MATCH_V6),
    .addr_hi (addr_hi),
    .addr_lo (addr_lo),
    .rule    (rule_rdata),
    .hit     (rule_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fmacl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: the count lookup decides the request, then a match walk visits one rule a cycle.
  always_comb begin
    state_next    = state;
    req.ready     = 1'b0;
    load_cnt      = 1'b0;
    step_idx      = 1'b0;
    set_vld       = 1'b0;
    clr_vld       = 1'b0;
    cnt_we        = 1'b0;
    rule_we       = 1'b0;
    load_res      = 1'b0;
    res_permitted = 1'b0;
    res_hit       = 1'b0;
    res_status    = fmacl_pkg::STATUS_OK;
    unique case (state)
      fmacl_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = fmacl_pkg::ST_COUNT;
        end
      end
      fmacl_pkg::ST_COUNT: begin
        load_cnt   = 1'b1;
        load_res   = 1'b1;
        state_next = fmacl_pkg::ST_DONE;
        case (op)
          fmacl_pkg::OP_ADD_V4, fmacl_pkg::OP_ADD_V6: begin
            if (!list_ok || (cnt_cur >= CNT_W'(RULES_PER_LIST))) begin
              res_status = fmacl_pkg::STATUS_FULL;
            end else begin
              rule_we = 1'b1;
              cnt_we  = 1'b1;
              set_vld = 1'b1;
            end
          end
          fmacl_pkg::OP_CLEAR: begin
            clr_vld = list_ok;
          end
          fmacl_pkg::OP_MATCH_V4, fmacl_pkg::OP_MATCH_V6: begin
            // An empty list permits; a list out of range answers deny.
            if (list_ok && (cnt_cur != '0)) begin
              load_res   = 1'b0;
              state_next = fmacl_pkg::ST_WALK;
            end else begin
              res_permitted = list_ok;
            end
          end
          default: begin
          end
        endcase
      end
      fmacl_pkg::ST_WALK: begin
        if (rule_hit) begin
          load_res      = 1'b1;
          res_permitted = rule_rdata.permit;
          res_hit       = 1'b1;
          state_next    = fmacl_pkg::ST_DONE;
        end else if (CNT_W'(idx + 1'b1) == cnt) begin
          // No rule hit: the verdict is the inverse of the last rule's permit.
          load_res      = 1'b1;
          res_permitted = ~rule_rdata.permit;
          state_next    = fmacl_pkg::ST_DONE;
        end else begin
          step_idx = 1'b1;
        end
      end
      fmacl_pkg::ST_DONE: begin
        if (rsp.ready) begin
          state_next = fmacl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fmacl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld <= '0;
    end else if (set_vld) begin
      cnt_vld[list_idx] <= 1'b1;
    end else if (clr_vld) begin
      cnt_vld[list_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op         <= fmacl_pkg::op_t'(req.opcode);
      list_ok    <= list_ok_in;
      list_idx   <= cnt_raddr;
      base       <= SW'(list_wide_in) * SW'(RULES_PER_LIST);
      addr_hi    <= req.addr_hi;
      addr_lo    <= req.addr_lo;
      ipv4_mask  <= req.ipv4_mask;
      prefix_len <= req.prefix_len;
      permit_in  <= req.permit_in;
    end
    if (load_cnt) begin
      cnt <= cnt_cur;
      idx <= '0;
    end else if (step_idx) begin
      idx <= CNT_W'(idx + 1'b1);
    end
    if (load_res) begin
      permitted    <= res_permitted;
      explicit_hit <= res_hit;
      status       <= res_status;
    end
  end

  assign rsp.valid        = (state == fmacl_pkg::ST_DONE);
  assign rsp.permitted    = permitted;
  assign rsp.explicit_hit = explicit_hit;
  assign rsp.status       = status;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the first-match IP access list block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fmacl_pkg::*;

  localparam int NUM_LISTS      = NUM_LISTS_DEF;
  localparam int RULES_PER_LIST = RULES_PER_LIST_DEF;

  // Opcodes the block does not define; it must answer them with all fields low.
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // Run length bounds. The cycle limit is many times the slowest legal run:
  // every request walking a full list, the longest sender gap and a long
  // receiver stall on every result, plus the two long receiver hold-offs.
  localparam int RANDOM_REQS    = 1950;
  localparam int DRAIN_EVERY    = 300;
  localparam int TAIL_CYCLES    = 40;
  localparam int CYCLE_LIMIT    = 2000000;
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_SPACING   = 900;

  // One request as the stimulus generator hands it to the driver. The drain
  // flag makes the driver wait until every outstanding verdict has arrived.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  list_index;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [31:0] ipv4_mask;
    logic [7:0]  prefix_len;
    logic        permit_in;
    logic        drain_first;
  } acl_req_t;

  // One verdict, in the order of the result channel fields.
  typedef struct packed {
    logic permitted;
    logic explicit_hit;
    logic status;
  } acl_verdict_t;

  logic clk;
  logic rst;

  fmacl_req_if req_ch ();
  fmacl_rsp_if rsp_ch ();

  first_match_ip_acl #(
    .NUM_LISTS      (NUM_LISTS),
    .RULES_PER_LIST (RULES_PER_LIST)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Requests waiting to be offered, verdicts waiting to come back.
  acl_req_t     pending_reqs[$];
  acl_verdict_t verdicts_due[$];

  // The testbench's own image of the rule lists, advanced at each accepted request.
  rule_t       acl_rules [NUM_LISTS][RULES_PER_LIST];
  int unsigned acl_fill  [NUM_LISTS];

  // The generator's view of the lists, kept in stimulus order. It lets the
  // generator aim matches at rules that really are present.
  rule_t gen_lists [NUM_LISTS][$];

  int unsigned accepted_reqs = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;

  // Driver and receiver bookkeeping.
  logic        req_taken   = 1'b0;
  bit          offering    = 1'b0;
  int unsigned gap_left    = 0;
  int unsigned hold_left   = 0;
  int unsigned stall_left  = 0;
  int unsigned next_hold_at = 500;

  // ---------------------------------------------------------------------------
  // Clock and reset. Reset is released on a falling edge, like every other
  // input.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Every block input is known from time zero on.
  initial begin
    req_ch.valid      = 1'b0;
    req_ch.opcode     = OP_CLEAR;
    req_ch.list_index = '0;
    req_ch.addr_hi    = '0;
    req_ch.addr_lo    = '0;
    req_ch.ipv4_mask  = '0;
    req_ch.prefix_len = '0;
    req_ch.permit_in  = 1'b0;
    rsp_ch.ready      = 1'b0;
    for (int l = 0; l < NUM_LISTS; l++) acl_fill[l] = 0;
  end

  // ---------------------------------------------------------------------------
  // Helpers shared by the generator and the verdict predictor.
  // ---------------------------------------------------------------------------

  // Mask of the leading len bits of a 128-bit IPv6 address; lengths above
  // 128 saturate, as the block does when a rule is stored.
  function automatic logic [127:0] prefix_keep(input int unsigned len);
    int unsigned n;
    n = (len > MAX_PREFIX) ? 32'(MAX_PREFIX) : len;
    if (n == 0) return '0;
    return ~128'd0 << (128 - n);
  endfunction

  // Short gaps most of the time, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Every fifth stretch of 160 requests runs with no idling on either side.
  function automatic bit calm_phase();
    return ((accepted_reqs / 160) % 5) == 4;
  endfunction

  // Does one stored rule hit the address? A rule of the other family never does.
  function automatic bit rule_covers(input rule_t rl, input bit v6,
                                     input logic [63:0] hi, input logic [63:0] lo);
    if (!v6)
      return (rl.kind == KIND_V4) && ((lo[31:0] & rl.mask_or_len) == rl.addr_lo[31:0]);
    if (rl.kind != KIND_V6) return 1'b0;
    // The stored value is not masked, so a value with bits set past its prefix
    // can never hit.
    return ({hi, lo} & prefix_keep(rl.mask_or_len)) == {rl.addr_hi, rl.addr_lo};
  endfunction

  // Verdict predictor: applies one accepted request to the list image and
  // returns the verdict the block owes for it.
  function automatic acl_verdict_t acl_decide(input acl_req_t r);
    acl_verdict_t v;
    rule_t        rl;
    int unsigned  li;
    logic         last;
    bit           found;
    v  = '0;
    li = 32'(r.list_index);
    case (r.opcode)
      OP_ADD_V4, OP_ADD_V6: begin
        if (li >= NUM_LISTS || acl_fill[li] >= RULES_PER_LIST) begin
          v.status = STATUS_FULL;
        end else begin
          rl.permit = r.permit_in;
          if (r.opcode == OP_ADD_V4) begin
            rl.kind        = KIND_V4;
            rl.addr_hi     = '0;
            rl.addr_lo     = {32'd0, r.addr_lo[31:0]};
            rl.mask_or_len = r.ipv4_mask;
          end else begin
            rl.kind        = KIND_V6;
            rl.addr_hi     = r.addr_hi;
            rl.addr_lo     = r.addr_lo;
            rl.mask_or_len = (r.prefix_len > MAX_PREFIX) ? 32'(MAX_PREFIX)
                                                         : 32'(r.prefix_len);
          end
          acl_rules[li][acl_fill[li]] = rl;
          acl_fill[li]++;
        end
      end
      OP_CLEAR: begin
        if (li < NUM_LISTS) acl_fill[li] = 0;
      end
      OP_MATCH_V4, OP_MATCH_V6: begin
        if (li < NUM_LISTS) begin
          // With no hit the default is the inverse of the last rule's permit,
          // whatever family that rule has; an empty list therefore permits.
          last  = 1'b0;
          found = 1'b0;
          for (int i = 0; i < acl_fill[li] && !found; i++) begin
            last  = acl_rules[li][i].permit;
            found = rule_covers(acl_rules[li][i], r.opcode == OP_MATCH_V6,
                                r.addr_hi, r.addr_lo);
          end
          v.permitted    = found ? last : ~last;
          v.explicit_hit = found;
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation.
  // ---------------------------------------------------------------------------

  // Queues one request and keeps the generator's view of the lists in step.
  task automatic queue_req(input acl_req_t r);
    rule_t rl;
    pending_reqs.push_back(r);
    case (r.opcode)
      OP_ADD_V4, OP_ADD_V6: begin
        if (gen_lists[r.list_index].size() < RULES_PER_LIST) begin
          rl.kind        = (r.opcode == OP_ADD_V6) ? KIND_V6 : KIND_V4;
          rl.permit      = r.permit_in;
          rl.addr_hi     = r.addr_hi;
          rl.addr_lo     = r.addr_lo;
          rl.mask_or_len = (r.opcode == OP_ADD_V6) ? {24'd0, r.prefix_len} : r.ipv4_mask;
          gen_lists[r.list_index].push_back(rl);
        end
      end
      OP_CLEAR: gen_lists[r.list_index].delete();
      default: ;
    endcase
  endtask

  // A request with random list, address, mask, prefix and permit fields; callers then set what matters.
  function automatic acl_req_t rand_req();
    acl_req_t r;
    r.opcode      = OP_CLEAR;
    r.list_index  = ($urandom_range(1, 0) == 0) ? 4'($urandom_range(3, 0))
                                                : 4'($urandom_range(NUM_LISTS - 1, 0));
    r.addr_hi     = {$urandom, $urandom};
    r.addr_lo     = {$urandom, $urandom};
    r.ipv4_mask   = $urandom;
    r.prefix_len  = 8'($urandom_range(255, 0));
    r.permit_in   = 1'($urandom_range(1, 0));
    r.drain_first = 1'b0;
    return r;
  endfunction

  function automatic acl_req_t make_req(input logic [2:0] op, input logic [3:0] li,
                                        input logic [63:0] hi, input logic [63:0] lo,
                                        input logic [31:0] m4, input logic [7:0] plen,
                                        input logic perm);
    acl_req_t r;
    r = '{op, li, hi, lo, m4, plen, perm, 1'b0};
    return r;
  endfunction

  // Random traffic: adds with mostly well-formed values, matches aimed mostly
  // at rules known to be in the list, a few clears and unknown opcodes.
  function automatic acl_req_t random_req();
    acl_req_t     r;
    rule_t        rl;
    logic [127:0] keep;
    int unsigned  roll;
    int unsigned  plen;
    r    = rand_req();
    roll = $urandom_range(99, 0);
    if (roll < 38) begin
      if ($urandom_range(1, 0) == 0) begin
        r.opcode = OP_ADD_V4;
        if ($urandom_range(9, 0) < 7) begin
          plen        = $urandom_range(32, 0);
          r.ipv4_mask = (plen == 0) ? 32'd0 : ~32'd0 << (32 - plen);
        end
        if ($urandom_range(9, 0) < 8) r.addr_lo[31:0] = r.addr_lo[31:0] & r.ipv4_mask;
      end else begin
        r.opcode = OP_ADD_V6;
        if ($urandom_range(99, 0) < 85) r.prefix_len = 8'($urandom_range(128, 0));
        if ($urandom_range(9, 0) < 8)
          {r.addr_hi, r.addr_lo} = {r.addr_hi, r.addr_lo} & prefix_keep(r.prefix_len);
      end
    end else if (roll < 40) begin
      r.opcode = OP_CLEAR;
    end else if (roll < 43) begin
      r.opcode = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    end else if (gen_lists[r.list_index].size() > 0 && $urandom_range(9, 0) < 7) begin
      // Keep the rule's significant bits, randomize the rest.
      rl = gen_lists[r.list_index][$urandom_range(gen_lists[r.list_index].size() - 1, 0)];
      if (rl.kind == KIND_V4) begin
        r.opcode        = OP_MATCH_V4;
        r.addr_lo[31:0] = (rl.addr_lo[31:0] & rl.mask_or_len)
                        | (r.addr_lo[31:0] & ~rl.mask_or_len);
      end else begin
        r.opcode = OP_MATCH_V6;
        keep     = prefix_keep(rl.mask_or_len);
        {r.addr_hi, r.addr_lo} = ({rl.addr_hi, rl.addr_lo} & keep)
                               | ({r.addr_hi, r.addr_lo} & ~keep);
      end
    end else begin
      r.opcode = ($urandom_range(1, 0) == 0) ? OP_MATCH_V4 : OP_MATCH_V6;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. Requests are presented on the falling edge. A request leaves the
  // queue once the monitor has seen it accepted; then a random gap may follow.
  // A request flagged for draining waits until no verdict is outstanding.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    acl_req_t head;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (offering && req_taken) begin
        void'(pending_reqs.pop_front());
        offering = 1'b0;
        gap_left = calm_phase() ? 0 : pick_gap();
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          if (!pending_reqs[0].drain_first || verdicts_due.size() == 0) offering = 1'b1;
        end
      end
      if (offering) begin
        head = pending_reqs[0];
        req_ch.opcode     <= head.opcode;
        req_ch.list_index <= head.list_index;
        req_ch.addr_hi    <= head.addr_hi;
        req_ch.addr_lo    <= head.addr_lo;
        req_ch.ipv4_mask  <= head.ipv4_mask;
        req_ch.prefix_len <= head.prefix_len;
        req_ch.permit_in  <= head.permit_in;
      end
      req_ch.valid <= offering;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. Ready is changed on the falling edge. Short random stalls, quiet
  // stretches without any, and twice a long hold-off while the sender keeps
  // offering requests, so the block sits finished and refuses new work.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    logic take;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (accepted_reqs >= next_hold_at) begin
        hold_left    = LONG_HOLD;
        next_hold_at = next_hold_at + HOLD_SPACING;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end else if (!calm_phase() && $urandom_range(99, 0) < 20) begin
        stall_left = pick_gap();
        take       = (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end else begin
        take = 1'b1;
      end
      rsp_ch.ready <= take;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Both channels are sampled on the rising edge. Each accepted
  // request is run through the predictor right away; each accepted result is
  // compared with the oldest outstanding verdict.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    acl_req_t     seen;
    acl_verdict_t got;
    acl_verdict_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        seen = make_req(req_ch.opcode, req_ch.list_index, req_ch.addr_hi, req_ch.addr_lo,
                        req_ch.ipv4_mask, req_ch.prefix_len, req_ch.permit_in);
        verdicts_due.push_back(acl_decide(seen));
        accepted_reqs++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = {rsp_ch.permitted, rsp_ch.explicit_hit, rsp_ch.status};
        if (verdicts_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing outstanding: expected none, actual %b",
                   $time, got);
        end else begin
          want = verdicts_due.pop_front();
          if (got !== want) begin
            mismatches++;
            $display({"%0t: verdict mismatch: expected permitted=%b hit=%b status=%b,",
                      " actual permitted=%b hit=%b status=%b"},
                     $time, want.permitted, want.explicit_hit, want.status,
                     got.permitted, got.explicit_hit, got.status);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    acl_req_t    r;
    logic [63:0] v6_hi;
    v6_hi = {$urandom, $urandom};

    // Directed part. Matches on an empty list permit, in both families.
    r = make_req(OP_MATCH_V4, 4'd0, {$urandom, $urandom}, {$urandom, $urandom}, '0, '0, 1'b0);
    r.drain_first = 1'b1;
    queue_req(r);
    queue_req(make_req(OP_MATCH_V6, 4'd0, '1, '1, '0, '0, 1'b0));
    // An IPv4 deny rule for 10.0.0.0/8; upper address bits are ignored.
    queue_req(make_req(OP_ADD_V4, 4'd0, '1, 64'h0000_0000_0A00_0000, 32'hFF00_0000, '0, 1'b0));
    queue_req(make_req(OP_MATCH_V4, 4'd0, '0, 64'hFFFF_FFFF_0A01_0203, '0, '0, 1'b0));
    queue_req(make_req(OP_MATCH_V4, 4'd0, '0, 64'h0000_0000_0B00_0000, '0, '0, 1'b0));
    // An IPv6 address never hits an IPv4 rule but still takes its default from it.
    queue_req(make_req(OP_MATCH_V6, 4'd0, '0, '0, '0, '0, 1'b1));
    queue_req(make_req(OP_ADD_V6, 4'd0, 64'h2001_0DB8_0000_0000, '0, '0, 8'd32, 1'b1));
    queue_req(make_req(OP_MATCH_V6, 4'd0, 64'h2001_0DB8_1234_5678, {$urandom, $urandom},
                       '0, '0, 1'b0));
    queue_req(make_req(OP_MATCH_V6, 4'd0, 64'h2001_0DB9_0000_0000, '0, '0, '0, 1'b0));
    // A prefix above 128 saturates to the full address.
    queue_req(make_req(OP_ADD_V6, 4'd1, '1, '1, '0, 8'hFF, 1'b1));
    queue_req(make_req(OP_MATCH_V6, 4'd1, '1, '1, '0, '0, 1'b0));
    queue_req(make_req(OP_MATCH_V6, 4'd1, '1, ~64'd1, '0, '0, 1'b0));
    // A zero-length prefix with a bit set in the value can never hit; the
    // clean one after it hits everything.
    queue_req(make_req(OP_ADD_V6, 4'd2, '0, 64'd1, '0, 8'd0, 1'b1));
    queue_req(make_req(OP_ADD_V6, 4'd2, '0, '0, '0, 8'd0, 1'b0));
    queue_req(make_req(OP_MATCH_V6, 4'd2, {$urandom, $urandom}, {$urandom, $urandom},
                       '0, '0, 1'b1));
    // An all-zero IPv4 mask matches any address.
    queue_req(make_req(OP_ADD_V4, 4'd3, '1, 64'hFFFF_FFFF_0000_0000, 32'd0, '1, 1'b1));
    queue_req(make_req(OP_MATCH_V4, 4'd3, '1, {$urandom, $urandom}, '1, '1, 1'b0));
    // A /64 rule: only the upper half of the address counts.
    queue_req(make_req(OP_ADD_V6, 4'd15, v6_hi, '0, '0, 8'd64, 1'b0));
    queue_req(make_req(OP_MATCH_V6, 4'd15, v6_hi, {$urandom, $urandom}, '0, '0, 1'b1));
    // Opcodes the block does not define.
    for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
      queue_req(make_req(3'(op), 4'd0, '1, '1, '1, '1, 1'b1));
    // A cleared list is empty again.
    queue_req(make_req(OP_CLEAR, 4'd0, '0, '0, '0, '0, 1'b0));
    queue_req(make_req(OP_MATCH_V4, 4'd0, '0, 64'h0000_0000_0A01_0203, '0, '0, 1'b0));

    // Random part, with a drain point now and then.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      r = random_req();
      r.drain_first = ((n % DRAIN_EVERY) == DRAIN_EVERY - 1);
      queue_req(r);
    end

    // Wait until every request is taken and every verdict has come back, then
    // give the block time to show any stray result.
    @(negedge rst);
    while (pending_reqs.size() != 0 || verdicts_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/fmacl_pkg.sv
src/fmacl_req_if.sv
src/fmacl_rsp_if.sv
src/fmacl_ram.sv
src/fmacl_match.sv
src/first_match_ip_acl.sv
tb/tb_top.sv
